// ===== hw/rtl/cks_pkg.sv =====
// ----------------------------------------------------------------------------
// cks_pkg: shared types and constants for the chroma key sharpen stream
// Payload structs, register indexes, frame limits and the 3-tap sharpen
// kernel used by the row and column passes.
// ----------------------------------------------------------------------------
package cks_pkg;

   // Line store depth and column index width
   localparam int MaxWidth = 1024;
   localparam int ColW     = $clog2(MaxWidth);

   // Register field widths
   localparam int FrameWidthW  = 11;
   localparam int FrameHeightW = 12;
   localparam int MarginW      = 8;
   localparam int CsrAddrW     = 2;
   localparam int CsrDataW     = 12;
   localparam int MinDim       = 3;

   // Register indexes
   localparam logic [CsrAddrW-1:0] CsrFrameWidth  = 2'd0;
   localparam logic [CsrAddrW-1:0] CsrFrameHeight = 2'd1;
   localparam logic [CsrAddrW-1:0] CsrKeyMargin   = 2'd2;

   // Reset values
   localparam int ResetFrameWidth  = 640;
   localparam int ResetFrameHeight = 480;
   localparam int ResetKeyMargin   = 20;
   localparam logic [ColW-1:0] ResetWidthLast =
      ColW'(((ResetFrameWidth > MaxWidth) ? MaxWidth : ResetFrameWidth) - 1);

   // Transaction opcodes
   localparam logic OpPixel = 1'b0;
   localparam logic OpDrain = 1'b1;

   localparam int PixelW = 24;
   typedef logic [PixelW-1:0] pixel_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] fg_ch0;
      logic [7:0] fg_ch1;
      logic [7:0] fg_ch2;
      logic [7:0] bg_ch0;
      logic [7:0] bg_ch1;
      logic [7:0] bg_ch2;
   } req_type;

   typedef struct packed {
      logic [7:0] out_ch0;
      logic [7:0] out_ch1;
      logic [7:0] out_ch2;
      logic       frame_last;
   } rsp_type;

   // 3-tap sharpen per channel: clamp(2c - (p>>1) - (n>>1), 0, 255)
   function automatic pixel_type sharpen(input pixel_type c, input pixel_type p,
                                         input pixel_type n);
      pixel_type          res;
      logic signed [10:0] v;
      res = '0;
      for (int k = 0; k < 3; k++) begin
         v = $signed({2'b00, c[8*k +: 8], 1'b0})
           - $signed({4'b0000, p[8*k+1 +: 7]})
           - $signed({4'b0000, n[8*k+1 +: 7]});
         if (v < 0) begin
            res[8*k +: 8] = 8'h00;
         end else if (v > 11'sd255) begin
            res[8*k +: 8] = 8'hFF;
         end else begin
            res[8*k +: 8] = v[7:0];
         end
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/cks_ram.sv =====
// ----------------------------------------------------------------------------
// cks_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module cks_ram #(
   parameter int Width = 24,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write and read; read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/chroma_key_sharpen_stream.sv =====
// ----------------------------------------------------------------------------
// chroma_key_sharpen_stream: chroma key followed by row and column sharpen
// Keys foreground against background, sharpens along rows and then down
// columns, and streams the final pixels out in raster order.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock and sustains that rate while the
// result side does not stall: every pixel or drain transaction passes a
// three-stage pipeline (key and position tracking, row sharpen with the line
// store read, column sharpen with the line store write) into an output
// register. Results trail their pixels by frame_width+1 transactions; after
// the last pixel of a frame, frame_width+1 drain transactions flush the tail;
// the final one carries frame_last. Two line stores of 1024 x 24 bits, each
// read once and written once per cycle, hold the row-sharpened and final
// pixels of the previous line; they need no clearing after reset. Stall on the
// result side backs up to req_stall within the same cycle. Write registers
// only while no transaction is in flight; a write of frame_width or
// frame_height restarts the frame.
module chroma_key_sharpen_stream (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  cks_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output cks_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [cks_pkg::CsrAddrW-1:0]   csr_addr,
   input  logic [cks_pkg::CsrDataW-1:0]   csr_wdata
);

   import cks_pkg::*;

   typedef struct packed {
      logic            is_tail;
      logic [ColW-1:0] col;
      logic            row_first;
      logic            emit;
      logic            col_edge;
      logic            last;
      pixel_type       centre;
      pixel_type       nxt;
   } item_type;

   typedef struct packed {
      logic            is_tail;
      logic [ColW-1:0] col;
      logic            row_first;
      logic            emit;
      logic            last;
   } col_ctrl_type;

   function automatic logic [ColW-1:0] width_last_of(input logic [FrameWidthW-1:0] v);
      logic [ColW-1:0] res;
      if (v < MinDim) begin
         res = ColW'(MinDim - 1);
      end else if (32'(v) > MaxWidth) begin
         res = ColW'(MaxWidth - 1);
      end else begin
         res = ColW'(v - 1'b1);
      end
      return res;
   endfunction

   // Configuration
   logic [ColW-1:0]         width_last_ff, width_last_in;
   logic [FrameHeightW-1:0] height_ff, height_in;
   logic [MarginW-1:0]      margin_ff, margin_in;
   logic                    geom_write;

   // Frame position
   logic [ColW-1:0]         in_col_ff, in_col_in;
   logic [FrameHeightW-1:0] in_row_ff, in_row_in;
   logic [ColW-1:0]         kq_col_ff, kq_col_in;
   logic [FrameHeightW-1:0] kq_row_ff, kq_row_in;
   logic                    tail_ff, tail_in;
   logic [ColW-1:0]         tail_col_ff, tail_col_in;
   pixel_type               keyed_ff, keyed_in;

   // Accept decode
   logic       req_fire;
   logic       frame_full;
   logic       started;
   logic       pix_take;
   logic       drain_take;
   logic       s1_load;
   logic [8:0] lim0, lim2;
   logic       key_hit;
   pixel_type  px;
   item_type   new_item;

   // Pipeline
   logic         s1_valid_ff, s1_valid_in;
   item_type     s1_item_ff, s1_item_in;
   logic         s1_adv;
   pixel_type    row_r;
   pixel_type    rprev_ff, rprev_in;
   logic         s2_valid_ff, s2_valid_in;
   col_ctrl_type s2_ctrl_ff, s2_ctrl_in;
   pixel_type    s2_r_ff, s2_r_in;
   logic         s2_adv;
   pixel_type    above;
   pixel_type    fprev;
   pixel_type    col_f;
   pixel_type    result;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   // Decode register writes
   always_comb begin
      width_last_in = width_last_ff;
      height_in     = height_ff;
      margin_in     = margin_ff;
      geom_write    = 1'b0;
      if (csr_we) begin
         unique case (csr_addr)
            CsrFrameWidth: begin
               width_last_in = width_last_of(csr_wdata[FrameWidthW-1:0]);
               geom_write    = 1'b1;
            end
            CsrFrameHeight: begin
               height_in  = (csr_wdata[FrameHeightW-1:0] < MinDim) ?
                            FrameHeightW'(MinDim) : csr_wdata[FrameHeightW-1:0];
               geom_write = 1'b1;
            end
            CsrKeyMargin: begin
               margin_in = csr_wdata[MarginW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Key the foreground against the background
   always_comb begin
      lim0    = {1'b0, req_data.fg_ch0} + {1'b0, margin_ff};
      lim2    = {1'b0, req_data.fg_ch2} + {1'b0, margin_ff};
      key_hit = ({1'b0, req_data.fg_ch1} > lim0) && ({1'b0, req_data.fg_ch1} > lim2);
      px      = key_hit ? {req_data.bg_ch2, req_data.bg_ch1, req_data.bg_ch0}
                        : {req_data.fg_ch2, req_data.fg_ch1, req_data.fg_ch0};
   end

   // Classify the accepted transaction
   assign req_fire   = req_valid && !req_stall;
   assign frame_full = (in_row_ff == height_ff);
   assign started    = (in_row_ff != '0) || (in_col_ff != '0);
   assign pix_take   = req_fire && (req_data.opcode == OpPixel) && !frame_full;
   assign drain_take = req_fire && (req_data.opcode == OpDrain) && frame_full;
   assign s1_load    = (pix_take && started) || drain_take;

   // Build the pipeline item for the previous pixel or a tail entry
   always_comb begin
      new_item.is_tail   = tail_ff;
      new_item.col       = tail_ff ? tail_col_ff : kq_col_ff;
      new_item.row_first = (kq_row_ff == FrameHeightW'(1));
      new_item.emit      = tail_ff || (kq_row_ff != '0);
      new_item.col_edge  = (kq_col_ff == '0) || (kq_col_ff == width_last_ff);
      new_item.last      = tail_ff && (tail_col_ff == width_last_ff);
      new_item.centre    = keyed_ff;
      new_item.nxt       = (req_data.opcode == OpPixel) ? px : '0;
   end

   // Advance frame position, enter and leave the tail flush
   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      kq_col_in   = kq_col_ff;
      kq_row_in   = kq_row_ff;
      tail_in     = tail_ff;
      tail_col_in = tail_col_ff;
      keyed_in    = keyed_ff;
      if (geom_write) begin
         in_col_in   = '0;
         in_row_in   = '0;
         tail_in     = 1'b0;
         tail_col_in = '0;
      end else if (pix_take) begin
         keyed_in  = px;
         kq_col_in = in_col_ff;
         kq_row_in = in_row_ff;
         if (in_col_ff == width_last_ff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end else if (drain_take && !tail_ff) begin
         tail_in     = 1'b1;
         tail_col_in = '0;
      end else if (drain_take) begin
         if (tail_col_ff == width_last_ff) begin
            in_col_in   = '0;
            in_row_in   = '0;
            tail_in     = 1'b0;
            tail_col_in = '0;
         end else begin
            tail_col_in = tail_col_ff + 1'b1;
         end
      end
   end

   // Stage 1: row sharpen, issue line store reads
   assign s1_adv    = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign row_r     = s1_item_ff.col_edge ? s1_item_ff.centre
                    : sharpen(s1_item_ff.centre, rprev_ff, s1_item_ff.nxt);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
         s1_item_in  = new_item;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rprev_in = (s1_adv && !s1_item_ff.is_tail) ? row_r : rprev_ff;
   end

   // Stage 2: column sharpen, write back both line stores
   assign s2_adv = s2_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign col_f  = s2_ctrl_ff.row_first ? above : sharpen(above, fprev, s2_r_ff);
   assign result = s2_ctrl_ff.is_tail ? above : col_f;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_ctrl_in  = s2_ctrl_ff;
      s2_r_in     = s2_r_ff;
      if (s1_adv) begin
         s2_valid_in          = 1'b1;
         s2_ctrl_in.is_tail   = s1_item_ff.is_tail;
         s2_ctrl_in.col       = s1_item_ff.col;
         s2_ctrl_in.row_first = s1_item_ff.row_first;
         s2_ctrl_in.emit      = s1_item_ff.emit;
         s2_ctrl_in.last      = s1_item_ff.last;
         s2_r_in              = row_r;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end
   end

   cks_ram #(
      .Width (PixelW),
      .Depth (MaxWidth)
   ) u_row_line (
      .clock   (clock),
      .wr_en   (s2_adv && !s2_ctrl_ff.is_tail),
      .wr_addr (s2_ctrl_ff.col),
      .wr_data (s2_r_ff),
      .rd_en   (s1_adv),
      .rd_addr (s1_item_ff.col),
      .rd_data (above)
   );

   cks_ram #(
      .Width (PixelW),
      .Depth (MaxWidth)
   ) u_final_line (
      .clock   (clock),
      .wr_en   (s2_adv && !s2_ctrl_ff.is_tail && s2_ctrl_ff.emit),
      .wr_addr (s2_ctrl_ff.col),
      .wr_data (col_f),
      .rd_en   (s1_adv),
      .rd_addr (s1_item_ff.col),
      .rd_data (fprev)
   );

   // Output register: load a result, drop it once taken
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (s2_adv && s2_ctrl_ff.emit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.out_ch0    = result[7:0];
         rsp_data_in.out_ch1    = result[15:8];
         rsp_data_in.out_ch2    = result[23:16];
         rsp_data_in.frame_last = s2_ctrl_ff.last;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff <= ResetWidthLast;
         height_ff     <= FrameHeightW'(ResetFrameHeight);
         margin_ff     <= MarginW'(ResetKeyMargin);
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         kq_col_ff     <= '0;
         kq_row_ff     <= '0;
         tail_ff       <= 1'b0;
         tail_col_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_last_ff <= width_last_in;
         height_ff     <= height_in;
         margin_ff     <= margin_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         kq_col_ff     <= kq_col_in;
         kq_row_ff     <= kq_row_in;
         tail_ff       <= tail_in;
         tail_col_ff   <= tail_col_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      keyed_ff    <= keyed_in;
      s1_item_ff  <= s1_item_in;
      rprev_ff    <= rprev_in;
      s2_ctrl_ff  <= s2_ctrl_in;
      s2_r_ff     <= s2_r_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hw/rtl/cks_checker.sv =====
// ----------------------------------------------------------------------------
// cks_checker: port-level checks for the chroma key sharpen stream
// Watches the result channel over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module cks_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cks_pkg::rsp_type rsp_data
);

   import cks_pkg::*;

   // Hold a stalled result transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result transaction dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // No result comes out of reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A frame end cannot be followed at once by another frame end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.frame_last |=> !(rsp_valid && rsp_data.frame_last))
      else $error("two frame ends back to back");

endmodule

bind chroma_key_sharpen_stream cks_checker u_cks_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for chroma_key_sharpen_stream
// Streams keyed and sharpened frames through the block under random idling on
// both channels and compares every result with an in-bench prediction of the
// key, row sharpen and column sharpen passes, kept in raster order.
// ----------------------------------------------------------------------------
module testbench;
   import cks_pkg::*;

   // Clock, reset and block inputs, all known from time zero
   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_we    = 1'b0;
   logic [CsrAddrW-1:0] csr_addr  = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   chroma_key_sharpen_stream i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // Transactions waiting to be offered and pixels waiting to come out
   req_type pending_items[$];
   rsp_type expected_pixels[$];

   // Shadow registers and pipeline state of the keyer and sharpen passes
   logic [FrameWidthW-1:0]  cfg_cols   = 11'(ResetFrameWidth);
   logic [FrameHeightW-1:0] cfg_rows   = 12'(ResetFrameHeight);
   logic [MarginW-1:0]      cfg_margin = 8'(ResetKeyMargin);
   int                      pix_in_count  = 0;
   int                      pix_out_count = 0;
   pixel_type               keyed_hold = '0;
   pixel_type               row_left   = '0;
   pixel_type               line_above_row   [MaxWidth] = '{default: '0};
   pixel_type               line_above_final [MaxWidth] = '{default: '0};

   // Idle control shared between the stimulus and the two channel processes
   int      send_idle_pct   = 0;
   int      recv_idle_pct   = 0;
   bit      calm            = 1'b0;
   bit      stall_hold_armed = 1'b0;
   bit      stall_hold_done  = 1'b0;
   int      stall_hold_left  = 0;
   int      send_gap        = 0;
   int      recv_gap        = 0;
   int      mismatch_count  = 0;
   int      result_index    = 0;
   rsp_type want_pixel;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic int eff_cols();
      if (cfg_cols < MinDim) return MinDim;
      if (cfg_cols > MaxWidth) return MaxWidth;
      return int'(cfg_cols);
   endfunction

   function automatic int eff_rows();
      return (cfg_rows < MinDim) ? MinDim : int'(cfg_rows);
   endfunction

   // Clamp 2c - p/2 - n/2 to a byte, per channel
   function automatic pixel_type sharpen_three_tap(input pixel_type c, input pixel_type p,
                                                   input pixel_type n);
      pixel_type res;
      int        v;
      int        k;
      res = '0;
      for (k = 0; k < 3; k++) begin
         v = 2 * int'(c[8*k +: 8]) - (int'(p[8*k +: 8]) >> 1) - (int'(n[8*k +: 8]) >> 1);
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         res[8*k +: 8] = 8'(v);
      end
      return res;
   endfunction

   function automatic void queue_result(input pixel_type px, input int pos, input int total);
      rsp_type r;
      r.out_ch0    = px[7:0];
      r.out_ch1    = px[15:8];
      r.out_ch2    = px[23:16];
      r.frame_last = (pos == total - 1);
      expected_pixels.push_back(r);
   endfunction

   // Row pass: center is the held keyed pixel, left is already sharpened
   function automatic pixel_type row_pass(input int q, input pixel_type right, input int w);
      int        c;
      pixel_type r;
      c = q % w;
      if (c == 0 || c == w - 1) r = keyed_hold;
      else r = sharpen_three_tap(keyed_hold, row_left, right);
      row_left = r;
      return r;
   endfunction

   // Column pass: emit the pixel one line above q, then store q's row value
   function automatic void column_pass(input int q, input pixel_type r, input int w,
                                       input int h);
      int        c;
      int        p;
      int        row;
      pixel_type f;
      c = q % w;
      if (q >= w) begin
         p   = q - w;
         row = p / w;
         if (row == 0 || row == h - 1) f = line_above_row[c];
         else f = sharpen_three_tap(line_above_row[c], line_above_final[c], r);
         line_above_final[c] = f;
         queue_result(f, p, w * h);
         pix_out_count++;
      end
      line_above_row[c] = r;
   endfunction

   // Advance the shadow pipeline by one accepted transaction
   function automatic void key_and_sharpen(input req_type t);
      int        w;
      int        h;
      int        n;
      int        q;
      pixel_type px;
      pixel_type r;
      w = eff_cols();
      h = eff_rows();
      n = w * h;
      if (t.opcode == OpPixel) begin
         if (pix_in_count >= n) return;
         if (int'(t.fg_ch1) > int'(t.fg_ch0) + int'(cfg_margin) &&
             int'(t.fg_ch1) > int'(t.fg_ch2) + int'(cfg_margin))
            px = {t.bg_ch2, t.bg_ch1, t.bg_ch0};
         else
            px = {t.fg_ch2, t.fg_ch1, t.fg_ch0};
         if (pix_in_count >= 1) begin
            q = pix_in_count - 1;
            r = row_pass(q, px, w);
            column_pass(q, r, w, h);
         end
         keyed_hold = px;
         pix_in_count++;
      end else begin
         if (pix_in_count < n || pix_out_count >= n) return;
         q = pix_out_count + w;
         if (q < n) begin
            r = row_pass(q, '0, w);
            column_pass(q, r, w, h);
         end else begin
            queue_result(line_above_row[pix_out_count % w], pix_out_count, n);
            pix_out_count++;
         end
      end
      // Wrap to a new frame once the last pixel is out
      if (pix_out_count >= n) begin
         pix_in_count  = 0;
         pix_out_count = 0;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Request driver: offer pending transactions, hold while stalled
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            key_and_sharpen(req_data);
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(99, 0) < send_idle_pct) begin
               send_gap = $urandom_range(12, 1) - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor: check in order, then pick the next stall
   // ------------------------------------------------------------------------
   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: result %0d %s expected %0d actual %0d",
                  $time, result_index, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: result %0d expected none actual ch0=%0d ch1=%0d ch2=%0d last=%0d",
                        $time, result_index, rsp_data.out_ch0, rsp_data.out_ch1,
                        rsp_data.out_ch2, rsp_data.frame_last);
               mismatch_count++;
            end else begin
               want_pixel = expected_pixels.pop_front();
               compare_field("out_ch0", want_pixel.out_ch0, rsp_data.out_ch0);
               compare_field("out_ch1", want_pixel.out_ch1, rsp_data.out_ch1);
               compare_field("out_ch2", want_pixel.out_ch2, rsp_data.out_ch2);
               compare_field("frame_last", 8'(want_pixel.frame_last), 8'(rsp_data.frame_last));
            end
            result_index++;
         end
         // Long hold once armed, so the block backs up into its input
         if (stall_hold_left > 0) begin
            stall_hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_hold_armed && !stall_hold_done && rsp_valid) begin
            stall_hold_done = 1'b1;
            stall_hold_left = 299;
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(99, 0) < recv_idle_pct) begin
            recv_gap = $urandom_range(12, 1) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic req_type pixel_item(input logic [7:0] f0, input logic [7:0] f1,
                                          input logic [7:0] f2, input logic [7:0] b0,
                                          input logic [7:0] b1, input logic [7:0] b2);
      req_type t;
      t.opcode = OpPixel;
      t.fg_ch0 = f0;
      t.fg_ch1 = f1;
      t.fg_ch2 = f2;
      t.bg_ch0 = b0;
      t.bg_ch1 = b1;
      t.bg_ch2 = b2;
      return t;
   endfunction

   // Drain with a random, ignored payload
   function automatic req_type drain_item();
      req_type t;
      t = pixel_item(8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom));
      t.opcode = OpDrain;
      return t;
   endfunction

   // Mix of key-colored, saturated and arbitrary foreground pixels
   function automatic req_type random_pixel();
      req_type t;
      int      sel;
      t   = pixel_item(8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom));
      sel = $urandom_range(9, 0);
      if (sel < 4) begin
         t.fg_ch1 = 8'($urandom_range(255, 64));
         t.fg_ch0 = 8'($urandom_range(int'(t.fg_ch1), 0));
         t.fg_ch2 = 8'($urandom_range(int'(t.fg_ch1), 0));
      end else if (sel == 4) begin
         t.fg_ch0 = $urandom_range(1, 0) ? 8'hFF : 8'h00;
         t.fg_ch1 = $urandom_range(1, 0) ? 8'hFF : 8'h00;
         t.fg_ch2 = $urandom_range(1, 0) ? 8'hFF : 8'h00;
      end
      return t;
   endfunction

   function automatic int pick_idle();
      case ($urandom_range(3, 0))
         0: return 0;
         1: return 5;
         2: return 20;
         default: return 45;
      endcase
   endfunction

   // Wait for every transaction and result, then let the pipeline settle
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_pixels.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrAddrW-1:0] idx, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= CsrDataW'(value);
      case (idx)
         CsrFrameWidth: begin
            cfg_cols      = FrameWidthW'(value);
            pix_in_count  = 0;
            pix_out_count = 0;
         end
         CsrFrameHeight: begin
            cfg_rows      = FrameHeightW'(value);
            pix_in_count  = 0;
            pix_out_count = 0;
         end
         CsrKeyMargin: cfg_margin = MarginW'(value);
         default: ;
      endcase
   endtask

   task automatic program_frame(input int cols, input int rows, input int margin);
      write_reg(CsrFrameWidth, cols);
      write_reg(CsrFrameHeight, rows);
      write_reg(CsrKeyMargin, margin);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Queue one frame, or its first limit_px pixels; noisy adds ignored items
   task automatic queue_frame(input int limit_px, input bit noisy, output int counted);
      int w;
      int n;
      int stray_at;
      int i;
      w        = eff_cols();
      n        = w * eff_rows();
      counted  = 0;
      stray_at = noisy ? $urandom_range(n - 1, 0) : -1;
      for (i = 0; i < limit_px; i++) begin
         if (i == stray_at) pending_items.push_back(drain_item());
         pending_items.push_back(random_pixel());
         counted++;
      end
      if (limit_px == n) begin
         if (noisy) pending_items.push_back(random_pixel());
         for (i = 0; i <= w; i++) begin
            pending_items.push_back(drain_item());
            counted++;
         end
         if (noisy) pending_items.push_back(drain_item());
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      int  random_items;
      int  counted;
      int  n;
      int  cols;
      int  rows;
      bit  truncated;
      bit  reprogram;
      random_items = 0;
      truncated    = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: partial frame, enough for the first 19 results
      send_idle_pct = 20;
      recv_idle_pct = 20;
      queue_frame(660, 1'b0, counted);
      wait_drained();

      // Directed frame: 3x3 from undersized settings, zero margin
      program_frame(1, 2, 0);
      pending_items.push_back(drain_item());
      pending_items.push_back(pixel_item(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
      pending_items.push_back(pixel_item(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
      pending_items.push_back(pixel_item(8'd10, 8'd11, 8'd10, 8'd1, 8'd2, 8'd3));
      pending_items.push_back(pixel_item(8'd10, 8'd10, 8'd9, 8'd200, 8'd201, 8'd202));
      pending_items.push_back(pixel_item(8'd255, 8'd128, 8'd0, 8'd7, 8'd7, 8'd7));
      pending_items.push_back(pixel_item(8'd0, 8'd20, 8'd255, 8'd9, 8'd9, 8'd9));
      pending_items.push_back(pixel_item(8'd10, 8'd11, 8'd11, 8'd50, 8'd60, 8'd70));
      pending_items.push_back(pixel_item(8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255));
      pending_items.push_back(pixel_item(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
      // frame is full: this pixel is dropped
      pending_items.push_back(pixel_item(8'd0, 8'd255, 8'd0, 8'd1, 8'd1, 8'd1));
      repeat (4) pending_items.push_back(drain_item());
      // frame is done: this drain is dropped
      pending_items.push_back(drain_item());
      wait_drained();

      // Back-pressure: long receiver hold while the sender keeps offering
      program_frame(8, 6, 30);
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      stall_hold_armed = 1'b1;
      queue_frame(48, 1'b0, counted);
      wait_drained();

      // Widest line from a saturated width register, tallest frame,
      // abort after the first few results
      send_idle_pct = 10;
      recv_idle_pct = 10;
      program_frame(2047, 4095, 255);
      queue_frame(1040, 1'b0, counted);
      wait_drained();

      // Narrowest line, tallest frame, widest margin, abort early
      program_frame(0, 4095, 255);
      queue_frame(30, 1'b0, counted);
      wait_drained();

      // Random frames, mostly small and well formed
      reprogram = 1'b1;
      while (random_items < 150) begin
         if (reprogram || truncated || $urandom_range(9, 0) < 6) begin
            wait_drained();
            case ($urandom_range(9, 0))
               0:       cols = $urandom_range(2, 0);
               1:       cols = $urandom_range(48, 13);
               default: cols = $urandom_range(12, 3);
            endcase
            rows = ($urandom_range(6, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(8, 3);
            program_frame(cols, rows,
                          $urandom_range(1, 0) ? $urandom_range(40, 0) : $urandom_range(255, 0));
            reprogram = 1'b0;
         end
         send_idle_pct = pick_idle();
         recv_idle_pct = pick_idle();
         n             = eff_cols() * eff_rows();
         truncated     = ($urandom_range(15, 0) == 0);
         queue_frame(truncated ? $urandom_range(n - 1, 1) : n,
                     ($urandom_range(4, 0) == 0), counted);
         random_items += counted;
      end

      // Close with one clean frame and no idling on either side
      wait_drained();
      calm = 1'b1;
      program_frame(5, 3, 20);
      queue_frame(15, 1'b0, counted);

      // Drain everything, allow for stray late results, then report
      wait_drained();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   initial begin
      #30_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
